>>> hw/rtl/gcd_pkg.sv
// Shared types and constants for the great-circle distance pipeline.
package gcd_pkg;

	localparam int CORDIC_STEPS = 28;
	localparam int SQRT_STEPS = 31;

	localparam logic [29:0] ATAN_PHASE [CORDIC_STEPS] = '{
		30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
		30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
		30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
		30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163,
		30'd81, 30'd41, 30'd20, 30'd10, 30'd5
	};

	localparam int CORDIC_GAIN = 652032874;
	localparam logic [31:0] HALF_PI_Q31 = 32'd3373259426;
	localparam logic [25:0] DIST_MAX = 26'h3FFFFFF;
	localparam logic [15:0] RADIUS_RESET = 16'd6371;
	localparam int ONE_Q30 = 1 << 30;

	// degrees to phase: split by 45 through a reciprocal, offset keeps it positive
	localparam int PH_MOD = 45;
	localparam int PH_OFFS_K = 745655;
	localparam int PH_OFFS = PH_MOD * PH_OFFS_K;
	localparam int PH_RECIP = 95443718;

	typedef struct packed {
		logic signed [32:0] x;
		logic signed [32:0] y;
		logic signed [32:0] z;
		logic [1:0] quad;
	} rot_t;

	typedef struct packed {
		logic [60:0] v;
		logic [61:0] root;
		logic signed [31:0] c;
	} sq_t;

	typedef struct packed {
		logic signed [33:0] x;
		logic signed [33:0] y;
		logic signed [33:0] z;
	} vec_t;

endpackage

>>> hw/rtl/gcd_phase.sv
// Fixed-point degrees to 32-bit binary phase, three pipeline stages.
module gcd_phase #(
	parameter int FRAC_BITS = 16
) (
	input  logic clk,
	input  logic signed [25:0] deg,
	output logic [31:0] phase
);
	import gcd_pkg::*;

	localparam int SH = 32 - FRAC_BITS;

	typedef logic [31:0] frac_tbl_t [PH_MOD];

	function automatic frac_tbl_t build_tbl();
		frac_tbl_t t;
		for (int r = 0; r < PH_MOD; r++) begin
			t[r] = 32'(((64'(r) << SH) + 64'd180) / 64'd360);
		end
		return t;
	endfunction

	localparam frac_tbl_t FRAC_TBL = build_tbl();

	logic signed [27:0] sum;
	logic [26:0] u_s1, u_s2;
	logic [53:0] prod;
	logic [20:0] kq_s2;
	logic [26:0] rem;
	logic [31:0] k;
	logic [31:0] phase_s3;

	assign sum = 28'(deg) + 28'(PH_OFFS);
	assign prod = 54'(u_s1) * 54'(PH_RECIP);
	assign rem = u_s2 - 27'(kq_s2) * 27'(PH_MOD);
	assign k = 32'(kq_s2) - 32'(PH_OFFS_K);

	always_ff @(posedge clk) begin
		u_s1 <= sum[26:0];
		u_s2 <= u_s1;
		kq_s2 <= prod[52:32];
		phase_s3 <= (k << (SH - 3)) + FRAC_TBL[rem[5:0]];
	end

	assign phase = phase_s3;

endmodule

>>> hw/rtl/gcd_rot_cell.sv
// One rotation-mode CORDIC step, registered.
module gcd_rot_cell #(
	parameter int STEP = 0
) (
	input  logic clk,
	input  gcd_pkg::rot_t d,
	output gcd_pkg::rot_t q
);
	import gcd_pkg::*;

	localparam logic signed [32:0] DZ = 33'(ATAN_PHASE[STEP]);

	rot_t n, q_q;

	always_comb begin
		n = d;
		if (!d.z[32]) begin
			n.x = d.x - (d.y >>> STEP);
			n.y = d.y + (d.x >>> STEP);
			n.z = d.z - DZ;
		end else begin
			n.x = d.x + (d.y >>> STEP);
			n.y = d.y - (d.x >>> STEP);
			n.z = d.z + DZ;
		end
	end

	always_ff @(posedge clk) begin
		q_q <= n;
	end

	assign q = q_q;

endmodule

>>> hw/rtl/gcd_sqrt_cell.sv
// One result bit of the integer square root, registered.
module gcd_sqrt_cell #(
	parameter int STEP = 0
) (
	input  logic clk,
	input  gcd_pkg::sq_t d,
	output gcd_pkg::sq_t q
);
	import gcd_pkg::*;

	localparam logic [61:0] BIT = 62'(1) << (60 - 2 * STEP);

	sq_t n, q_q;
	logic [61:0] trial;

	assign trial = d.root + BIT;

	always_comb begin
		n = d;
		if (62'(d.v) >= trial) begin
			n.v = d.v - trial[60:0];
			n.root = (d.root >> 1) + BIT;
		end else begin
			n.root = d.root >> 1;
		end
	end

	always_ff @(posedge clk) begin
		q_q <= n;
	end

	assign q = q_q;

endmodule

>>> hw/rtl/gcd_vec_cell.sv
// One vectoring-mode CORDIC step, registered.
module gcd_vec_cell #(
	parameter int STEP = 0
) (
	input  logic clk,
	input  gcd_pkg::vec_t d,
	output gcd_pkg::vec_t q
);
	import gcd_pkg::*;

	localparam logic signed [33:0] DZ = 34'(ATAN_PHASE[STEP]);

	vec_t n, q_q;

	always_comb begin
		if (!d.y[33]) begin
			n.x = d.x + (d.y >>> STEP);
			n.y = d.y - (d.x >>> STEP);
			n.z = d.z + DZ;
		end else begin
			n.x = d.x - (d.y >>> STEP);
			n.y = d.y + (d.x >>> STEP);
			n.z = d.z - DZ;
		end
	end

	always_ff @(posedge clk) begin
		q_q <= n;
	end

	assign q = q_q;

endmodule

>>> hw/rtl/great_circle_distance.sv
// Top level: spherical law of cosines distance, fully pipelined.
// Takes one pair of points per clock; busy never rises. Each result appears
// on distance_km with a one-cycle done strobe after passing the phase
// converters, the 28-cell sine/cosine CORDIC rows, the 31-cell square-root
// row and the 28-cell arc cosine row. Results cannot be held off, so capture
// done when it comes. cfg_ready is always high; write the radius only while
// no item is in flight.
module great_circle_distance #(
	parameter int ANGLE_FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic signed [23:0] lat_first,
	input  logic signed [24:0] lon_first,
	input  logic signed [23:0] lat_second,
	input  logic signed [24:0] lon_second,
	output logic done,
	output logic [25:0] distance_km,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [15:0] cfg_data
);
	import gcd_pkg::*;

	localparam int LAT = 97;

	logic [LAT-1:0] vld_q;
	logic [15:0] radius_q;

	logic signed [25:0] deg [3];
	logic [31:0] ph [3];
	rot_t rch [3][CORDIC_STEPS+1];

	logic signed [32:0] cs_s1 [3];
	logic signed [32:0] sn_s1 [3];

	logic signed [65:0] m_ss, m_cc;
	logic signed [33:0] ss_s2, cc_s2, ss_s3, ccd_s3;
	logic signed [32:0] cd_s2;
	logic signed [66:0] m_ccd;
	logic signed [34:0] csum;
	logic signed [31:0] cv_s4;
	logic signed [63:0] m_sq;
	logic [63:0] sq_diff;

	sq_t sch [SQRT_STEPS+1];
	vec_t vch [CORDIC_STEPS+1];
	logic [30:0] sroot;

	logic signed [33:0] zf;
	logic [31:0] theta;
	logic [63:0] m_rad;
	logic [31:0] rad_s1;
	logic [47:0] m_dist;
	logic [48:0] dist_r;
	logic [25:0] dist_q;

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			radius_q <= RADIUS_RESET;
		end else begin
			vld_q <= {vld_q[LAT-2:0], start};
			if (cfg_valid) begin
				radius_q <= cfg_data;
			end
		end
	end

	assign deg[0] = 26'(lat_first);
	assign deg[1] = 26'(lat_second);
	assign deg[2] = 26'(lon_second) - 26'(lon_first);

	for (genvar g = 0; g < 3; g++) begin : g_ang
		gcd_phase #(.FRAC_BITS(ANGLE_FRAC_BITS)) u_phase (
			.clk  (clk),
			.deg  (deg[g]),
			.phase(ph[g])
		);

		assign rch[g][0].x = 33'(CORDIC_GAIN);
		assign rch[g][0].y = '0;
		assign rch[g][0].z = 33'(ph[g][29:0]);
		assign rch[g][0].quad = ph[g][31:30];

		for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
			gcd_rot_cell #(.STEP(i)) u_cell (
				.clk(clk),
				.d  (rch[g][i]),
				.q  (rch[g][i+1])
			);
		end

		always_ff @(posedge clk) begin
			case (rch[g][CORDIC_STEPS].quad)
				2'd0: begin
					cs_s1[g] <= rch[g][CORDIC_STEPS].x;
					sn_s1[g] <= rch[g][CORDIC_STEPS].y;
				end
				2'd1: begin
					cs_s1[g] <= -rch[g][CORDIC_STEPS].y;
					sn_s1[g] <= rch[g][CORDIC_STEPS].x;
				end
				2'd2: begin
					cs_s1[g] <= -rch[g][CORDIC_STEPS].x;
					sn_s1[g] <= -rch[g][CORDIC_STEPS].y;
				end
				default: begin
					cs_s1[g] <= rch[g][CORDIC_STEPS].y;
					sn_s1[g] <= -rch[g][CORDIC_STEPS].x;
				end
			endcase
		end
	end

	// central cosine
	assign m_ss = 66'(sn_s1[0]) * 66'(sn_s1[1]);
	assign m_cc = 66'(cs_s1[0]) * 66'(cs_s1[1]);
	assign m_ccd = 67'(cc_s2) * 67'(cd_s2);
	assign csum = 35'(ss_s3) + 35'(ccd_s3);

	always_ff @(posedge clk) begin
		ss_s2 <= m_ss[63:30];
		cc_s2 <= m_cc[63:30];
		cd_s2 <= cs_s1[2];
		ss_s3 <= ss_s2;
		ccd_s3 <= m_ccd[63:30];
		if (csum > 35'(ONE_Q30)) begin
			cv_s4 <= 32'(ONE_Q30);
		end else if (csum < -35'(ONE_Q30)) begin
			cv_s4 <= -32'(ONE_Q30);
		end else begin
			cv_s4 <= csum[31:0];
		end
	end

	// sine of the central angle
	assign m_sq = 64'(cv_s4) * 64'(cv_s4);
	assign sq_diff = (64'd1 << 60) - m_sq;

	always_ff @(posedge clk) begin
		sch[0].v <= sq_diff[60:0];
		sch[0].root <= '0;
		sch[0].c <= cv_s4;
	end

	for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
		gcd_sqrt_cell #(.STEP(j)) u_cell (
			.clk(clk),
			.d  (sch[j]),
			.q  (sch[j+1])
		);
	end

	// arc cosine
	assign sroot = sch[SQRT_STEPS].root[30:0];

	always_comb begin
		if (sch[SQRT_STEPS].c < 0) begin
			vch[0].x = 34'(sroot);
			vch[0].y = -34'(sch[SQRT_STEPS].c);
			vch[0].z = 34'(ONE_Q30);
		end else begin
			vch[0].x = 34'(sch[SQRT_STEPS].c);
			vch[0].y = 34'(sroot);
			vch[0].z = '0;
		end
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_vec
		gcd_vec_cell #(.STEP(i)) u_cell (
			.clk(clk),
			.d  (vch[i]),
			.q  (vch[i+1])
		);
	end

	// radians, then distance
	assign zf = vch[CORDIC_STEPS].z;

	always_comb begin
		if (zf < 0) begin
			theta = '0;
		end else if (zf > (34'sd1 <<< 31)) begin
			theta = 32'h8000_0000;
		end else begin
			theta = zf[31:0];
		end
	end

	assign m_rad = 64'(theta) * 64'(HALF_PI_Q31) + (64'd1 << 30);
	assign m_dist = 48'(rad_s1) * 48'(radius_q);
	assign dist_r = 49'(m_dist) + (49'd1 << 21);

	always_ff @(posedge clk) begin
		rad_s1 <= m_rad[62:31];
		if (dist_r[48:22] > 27'(DIST_MAX)) begin
			dist_q <= DIST_MAX;
		end else begin
			dist_q <= dist_r[47:22];
		end
	end

	assign done = vld_q[LAT-1];
	assign distance_km = dist_q;

`ifndef SYNTHESIS
	a_start_done: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##(LAT) done)
		else $error("start transfer without result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!start |-> ##(LAT) !done)
		else $error("result without start transfer");

	a_zero_radius: assert property (@(posedge clk) disable iff (!arst_n)
		done && radius_q == '0 |-> distance_km == '0)
		else $error("nonzero distance on zero radius");

	a_rot_residual: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[30] |-> rch[0][CORDIC_STEPS].z < 33'sd64 && rch[0][CORDIC_STEPS].z > -33'sd64)
		else $error("rotation CORDIC did not converge");
`endif

endmodule

>>> tb/tb_top.sv
// Testbench for great_circle_distance: directed and random point pairs, checked against a predictor.
`timescale 1ns / 100ps

module tb_top;
	import gcd_pkg::*;

	localparam longint DEG = 65536;
	localparam int PIPE_WAIT = 110;

	typedef struct {
		logic signed [23:0] la1;
		logic signed [24:0] lo1;
		logic signed [23:0] la2;
		logic signed [24:0] lo2;
	} pair_t;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	logic signed [23:0] lat_first = 0;
	logic signed [24:0] lon_first = 0;
	logic signed [23:0] lat_second = 0;
	logic signed [24:0] lon_second = 0;
	logic done;
	logic [25:0] distance_km;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [15:0] cfg_data = 0;

	pair_t pending_pairs[$];
	logic [25:0] expected_dist[$];
	logic [15:0] radius_now = RADIUS_RESET;
	logic took = 0;
	logic hold_tx = 0;
	int burst_left = 5;
	int gap_left = 0;
	int errors = 0;
	int n_checked = 0;
	int n_cfg = 0;

	great_circle_distance dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.lat_first(lat_first), .lon_first(lon_first),
		.lat_second(lat_second), .lon_second(lon_second),
		.done(done), .distance_km(distance_km),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	function automatic logic [31:0] deg_to_phase(longint d);
		longint num, q;
		num = 2 * (d * (longint'(1) << (32 - 16))) + 360;
		q = num / 720;
		if (num % 720 < 0)
			q--;
		return q[31:0];
	endfunction

	task automatic rotate(input logic [31:0] p, output longint cs, output longint sn);
		longint x, y, z, dx, dy;
		x = CORDIC_GAIN;
		y = 0;
		z = longint'(p[29:0]);
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= longint'(ATAN_PHASE[i]);
			end else begin
				x += dx; y -= dy; z += longint'(ATAN_PHASE[i]);
			end
		end
		case (p[31:30])
			2'd0: begin cs = x; sn = y; end
			2'd1: begin cs = -y; sn = x; end
			2'd2: begin cs = -x; sn = -y; end
			default: begin cs = y; sn = -x; end
		endcase
	endtask

	function automatic longint int_sqrt(longint unsigned v);
		longint unsigned root, b;
		root = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= root + b) begin
				v -= root + b;
				root = (root >> 1) + b;
			end else begin
				root >>= 1;
			end
			b >>= 2;
		end
		return longint'(root);
	endfunction

	function automatic longint acos_phase(longint c);
		longint s, x, y, z, dx, dy;
		s = int_sqrt(longint'(ONE_Q30) * ONE_Q30 - c * c);
		if (c < 0) begin
			x = s; y = -c; z = longint'(1) << 30;
		end else begin
			x = c; y = s; z = 0;
		end
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x += dx; y -= dy; z += longint'(ATAN_PHASE[i]);
			end else begin
				x -= dx; y += dy; z -= longint'(ATAN_PHASE[i]);
			end
		end
		if (z < 0)
			z = 0;
		if (z > (longint'(1) << 31))
			z = longint'(1) << 31;
		return z;
	endfunction

	task automatic predict_distance(input pair_t p, input logic [15:0] radius,
			output logic [25:0] dist_exp);
		longint c1, s1, c2, s2, cd, sd, cv;
		longint unsigned rad, km;
		rotate(deg_to_phase(longint'(p.la1)), c1, s1);
		rotate(deg_to_phase(longint'(p.la2)), c2, s2);
		rotate(deg_to_phase(longint'(p.lo2) - longint'(p.lo1)), cd, sd);
		cv = ((s1 * s2) >>> 30) + ((((c1 * c2) >>> 30) * cd) >>> 30);
		if (cv > ONE_Q30)
			cv = ONE_Q30;
		if (cv < -longint'(ONE_Q30))
			cv = -longint'(ONE_Q30);
		rad = (longint'(acos_phase(cv)) * longint'(HALF_PI_Q31) + (64'd1 << 30)) >> 31;
		km = (rad * radius + (64'd1 << 21)) >> 22;
		if (km > DIST_MAX)
			km = DIST_MAX;
		dist_exp = km[25:0];
	endtask

	// sender: bursts and gaps, optional hold
	always @(negedge clk) begin
		pair_t p;
		if (arst_n && !(start && !took)) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				start <= 0;
			end else if (!hold_tx && pending_pairs.size() > 0) begin
				p = pending_pairs.pop_front();
				lat_first <= p.la1;
				lon_first <= p.lo1;
				lat_second <= p.la2;
				lon_second <= p.lo2;
				start <= 1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 30);
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				start <= 0;
			end
		end
	end

	// acceptance, prediction and result check
	always @(posedge clk) begin
		pair_t p;
		logic [25:0] want;
		took <= start && !busy;
		if (cfg_valid && cfg_ready) begin
			radius_now <= cfg_data;
			n_cfg++;
		end
		if (start && !busy) begin
			p.la1 = lat_first; p.lo1 = lon_first;
			p.la2 = lat_second; p.lo2 = lon_second;
			predict_distance(p, radius_now, want);
			expected_dist.push_back(want);
		end
		if (done) begin
			if (expected_dist.size() == 0) begin
				$display("%0t: unexpected result distance_km=%0d", $time, distance_km);
				errors++;
			end else begin
				want = expected_dist.pop_front();
				n_checked++;
				if (distance_km !== want) begin
					$display("%0t: distance_km expected %0d actual %0d",
						$time, want, distance_km);
					errors++;
				end
			end
		end
	end

	function automatic void add_pair(longint a, longint b, longint c, longint d);
		pair_t p;
		p.la1 = 24'(a); p.lo1 = 25'(b); p.la2 = 24'(c); p.lo2 = 25'(d);
		pending_pairs.push_back(p);
	endfunction

	function automatic longint rand_span(longint lim);
		return longint'($urandom_range(0, 2 * lim)) - lim;
	endfunction

	function automatic void add_random(int n);
		longint a, b, c, d;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 9))
				0: begin
					// any bit pattern the ports allow
					a = rand_span(24'sh7FFFFF); b = rand_span(25'sh0FFFFFF);
					c = rand_span(24'sh7FFFFF); d = rand_span(25'sh0FFFFFF);
					if ($urandom_range(0, 1)) a = -(longint'(1) << 23);
					if ($urandom_range(0, 1)) b = -(longint'(1) << 24);
				end
				1: begin
					// nearly the same point
					a = rand_span(90 * DEG); b = rand_span(180 * DEG);
					c = a + rand_span(64); d = b + rand_span(64);
					if (c > 90 * DEG) c = 90 * DEG;
					if (d > 180 * DEG) d = 180 * DEG;
				end
				2: begin
					// nearly antipodal
					a = rand_span(90 * DEG); b = rand_span(180 * DEG);
					c = -a + rand_span(64);
					d = (b > 0 ? b - 180 * DEG : b + 180 * DEG) + rand_span(64);
					if (c > 90 * DEG) c = 90 * DEG;
					if (c < -90 * DEG) c = -90 * DEG;
				end
				default: begin
					a = rand_span(90 * DEG); b = rand_span(180 * DEG);
					c = rand_span(90 * DEG); d = rand_span(180 * DEG);
				end
			endcase
			add_pair(a, b, c, d);
		end
	endfunction

	task automatic drain();
		wait (pending_pairs.size() == 0 && !start && expected_dist.size() == 0);
		repeat (PIPE_WAIT) @(posedge clk);
	endtask

	task automatic write_radius(logic [15:0] r);
		@(negedge clk);
		cfg_data <= r;
		cfg_valid <= 1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;

		add_pair(0, 0, 0, 0);
		add_pair(0, 0, 0, 180 * DEG);
		add_pair(90 * DEG, 0, -90 * DEG, 0);
		add_pair(90 * DEG, 180 * DEG, 90 * DEG, -180 * DEG);
		add_pair(-90 * DEG, -180 * DEG, -90 * DEG, 180 * DEG);
		add_pair(90 * DEG, 0, 0, 0);
		add_pair(0, -180 * DEG, 0, 180 * DEG);
		add_pair(45 * DEG, 90 * DEG, -45 * DEG, -90 * DEG);
		add_pair(1, 1, 0, 0);
		add_pair(-1, -1, 1, 1);
		add_pair(24'sh7FFFFF, 25'sh0FFFFFF, -(1 << 23), -(1 << 24));
		add_pair(-(1 << 23), -(1 << 24), 24'sh7FFFFF, 25'sh0FFFFFF);
		add_pair(24'sh7FFFFF, -(1 << 24), 24'sh7FFFFF, 25'sh0FFFFFF);
		add_pair(51 * DEG + 32768, 0, 40 * DEG + 46000, -74 * DEG);
		add_pair(-33 * DEG, 151 * DEG, 35 * DEG, 139 * DEG);
		add_pair(30 * DEG, 10 * DEG, 30 * DEG, 10 * DEG + 1);
		add_pair(0, 0, 0, 179 * DEG + 65535);
		add_pair(180 * DEG, 0, -180 * DEG, 360 * DEG);
		drain();

		write_radius(16'hFFFF);
		add_random(140);
		drain();
		write_radius(16'd1);
		add_random(100);
		drain();
		write_radius(16'd0);
		add_pair(0, 0, 0, 180 * DEG);
		add_random(20);
		drain();
		write_radius(16'($urandom_range(2, 65534)));
		add_random(100);
		add_random(100);
		// the sender holds mid-stream until everything in flight is back
		wait (pending_pairs.size() < 50);
		hold_tx = 1;
		wait (!start && expected_dist.size() == 0);
		hold_tx = 0;
		drain();
		write_radius(RADIUS_RESET);
		add_random(220);
		drain();

		$display("Checked %0d distances over %0d radius writes, extremes and random pairs.",
			n_checked, n_cfg);
		if (errors == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("tb_top failed");
		$finish;
	end

endmodule
